@@ src/gbc_pkg.sv @@
// ----------------------------------------------------------------------------
// gbc_pkg: shared constants and types of the gyro bias calibration block
// calibration length, field widths, register indexes and lane control
// ----------------------------------------------------------------------------
package gbc_pkg;

    localparam int AXES       = 3;
    localparam int SAMPLE_W   = 16;
    localparam int CAL_POINTS = 400;

    // countdown holds CAL_POINTS itself
    localparam int CNT_W = $clog2(CAL_POINTS + 1);
    // sum of CAL_POINTS samples, signed
    localparam int SUM_W = SAMPLE_W + $clog2(CAL_POINTS);
    // magnitude of any reachable sum
    localparam int MAG_W = SUM_W - 1;

    localparam logic [CNT_W-1:0] CAL_CNT = CNT_W'(CAL_POINTS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(1);

    // reciprocal of CAL_POINTS scaled by 2^RECIP_SHIFT, rounded down
    localparam int RECIP_SHIFT = 32;
    localparam logic [63:0] RECIP_WIDE = (64'd1 << RECIP_SHIFT) / 64'(CAL_POINTS);
    localparam logic [RECIP_SHIFT-1:0] RECIP = RECIP_WIDE[RECIP_SHIFT-1:0];

    // configuration register indexes
    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] CFG_GLITCH_LIMIT  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_DEV_THRESHOLD = 1'b1;

    localparam int CFG_W = 16;
    localparam logic [CFG_W-1:0] GLITCH_LIMIT_RST  = 16'd800;
    localparam logic [CFG_W-1:0] DEV_THRESHOLD_RST = 16'd30;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [SUM_W-1:0]    t_sum;

    // per-item control shared by the three axis lanes
    typedef struct packed {
        logic in_run;     // item belongs to a calibration run
        logic clr_sum;    // first item of a run, sum restarts
        logic skip_bias;  // failed check, sample passes uncorrected
    } t_lane_ctl;

endpackage

@@ src/gyro_bias_calibrate_and_deglitch_core.sv @@
// ----------------------------------------------------------------------------
// gyro_bias_calibrate_and_deglitch_core: gyro bias calibration and deglitching
// three-axis rate samples in, bias-corrected glitch-limited rates out
// ----------------------------------------------------------------------------
// One item is one three-axis gyro sample; every item gives exactly one result
// item. After reset, and from any item with start_cal set, a calibration run
// of CAL_POINTS items sums each axis while the outputs ramp toward zero; at the
// end of the run each bias is the sum divided by CAL_POINTS, rounded toward
// zero. The first item after a run is checked against the biases: if any axis
// is further than deviation_threshold away, that item passes uncorrected and a
// new run begins with the next item; otherwise bias_good rises. Every output is
// the corrected sample saturated to 16 bits and held within glitch_limit of the
// previous output of its axis. Throughput is one item per clock while the output
// is not stalled; an item is taken into the input register and then moves to the
// result register, from which it is presented. Apart from output stalls, the
// only pause comes after the last item of a calibration run: no item is taken
// while the reciprocal-multiply bias divider works. Configuration writes are to
// go in only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module gyro_bias_calibrate_and_deglitch_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // sample stream in
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [47:0]                       i_s_tdata,  // rate_x_in, rate_y_in, rate_z_in
    input  logic [0:0]                        i_s_tuser,  // start_cal
    // corrected stream out
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [47:0]                       o_m_tdata,  // rate_x_out, rate_y_out, rate_z_out
    output logic [1:0]                        o_m_tuser,  // calibrating, bias_good
    // configuration writes
    input  logic                              i_cfg_wr_en,
    input  logic [gbc_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [gbc_pkg::CFG_W-1:0]         i_cfg_wdata
);
    import gbc_pkg::*;

    // configuration
    logic [CFG_W-1:0] r_glitch_limit;
    logic [CFG_W-1:0] r_dev_threshold;

    // input register
    logic    r_in_vld;
    t_sample r_in_rate [AXES];
    logic    r_in_start;

    // result register
    logic    r_out_vld;
    t_sample r_out_rate [AXES];
    logic    r_out_cal;
    logic    r_out_good;

    // calibration state
    t_sum             r_sum  [AXES];
    t_sample          r_bias [AXES];
    t_sample          r_prev [AXES];
    logic [CNT_W-1:0] r_cnt;
    logic             r_passed;

    // lane and divider signals
    t_lane_ctl        w_ctl;
    t_sum             w_sum_next [AXES];
    logic [AXES-1:0]  w_dev_bad;
    t_sample          w_rate [AXES];
    logic [AXES-1:0]  w_div_busy;
    logic [AXES-1:0]  w_div_done;
    t_sample          w_quot [AXES];

    logic             w_s_acc;
    logic             w_out_free;
    logic             w_adv;
    logic [CNT_W-1:0] w_cnt_eff;
    logic             w_bad;
    logic             w_div_start;
    logic [CNT_W-1:0] n_cnt;
    logic             n_passed;

    // ---- handshake ----
    // the result register frees up when its item is taken; the input register
    // moves on whenever the result register can take the next one and the
    // divider is not writing new biases
    assign w_out_free = !r_out_vld || i_m_tready;
    assign w_adv      = r_in_vld && w_out_free && !(|w_div_busy);
    assign o_s_tready = !r_in_vld || w_adv;
    assign w_s_acc    = i_s_tvalid && o_s_tready;

    // ---- per-item control ----
    always_comb begin
        w_cnt_eff         = r_in_start ? CAL_CNT : r_cnt;
        w_ctl.in_run      = (w_cnt_eff != '0);
        w_ctl.clr_sum     = (w_cnt_eff == CAL_CNT);
        // first live item after a run that fails the deviation check
        w_bad             = !w_ctl.in_run && !r_passed && (|w_dev_bad);
        w_ctl.skip_bias   = w_bad;
        w_div_start       = w_adv && w_ctl.in_run && (w_cnt_eff == CNT_LAST);

        priority if (w_ctl.in_run) begin
            n_cnt = w_cnt_eff - CNT_LAST;
        end else if (w_bad) begin
            n_cnt = CAL_CNT;
        end else begin
            n_cnt = r_cnt;
        end
        n_passed = !w_ctl.in_run && (r_passed || !w_bad);
    end

    // ---- axis lanes and bias dividers ----
    for (genvar g = 0; g < AXES; g++) begin : g_axis
        gbc_lane u_lane (
            .i_ctl          (w_ctl),
            .i_sample       (r_in_rate[g]),
            .i_sum          (r_sum[g]),
            .i_bias         (r_bias[g]),
            .i_prev         (r_prev[g]),
            .i_glitch_limit (r_glitch_limit),
            .i_threshold    (r_dev_threshold),
            .o_sum_next     (w_sum_next[g]),
            .o_dev_bad      (w_dev_bad[g]),
            .o_rate         (w_rate[g])
        );

        gbc_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (w_div_start),
            .i_sum   (w_sum_next[g]),
            .o_busy  (w_div_busy[g]),
            .o_done  (w_div_done[g]),
            .o_quot  (w_quot[g])
        );
    end

    // ---- configuration ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glitch_limit  <= GLITCH_LIMIT_RST;
            r_dev_threshold <= DEV_THRESHOLD_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                CFG_GLITCH_LIMIT:  r_glitch_limit  <= i_cfg_wdata;
                CFG_DEV_THRESHOLD: r_dev_threshold <= i_cfg_wdata;
            endcase
        end
    end

    // ---- control registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_cnt     <= CAL_CNT;
            r_passed  <= 1'b0;
        end else begin
            if (w_s_acc) begin
                r_in_vld <= 1'b1;
            end else if (w_adv) begin
                r_in_vld <= 1'b0;
            end

            if (w_adv) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end

            if (w_adv) begin
                r_cnt    <= n_cnt;
                r_passed <= n_passed;
            end
        end
    end

    // ---- axis state ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < AXES; i++) begin
                r_sum[i]  <= '0;
                r_bias[i] <= '0;
                r_prev[i] <= '0;
            end
        end else begin
            for (int i = 0; i < AXES; i++) begin
                if (w_adv) begin
                    r_prev[i] <= w_rate[i];
                    if (w_ctl.in_run) begin
                        r_sum[i] <= w_sum_next[i];
                    end
                end
                // biases land when the divider finishes; items wait meanwhile
                if (w_div_done[i]) begin
                    r_bias[i] <= w_quot[i];
                end
            end
        end
    end

    // ---- payload registers ----
    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_in_rate[0] <= i_s_tdata[15:0];
            r_in_rate[1] <= i_s_tdata[31:16];
            r_in_rate[2] <= i_s_tdata[47:32];
            r_in_start   <= i_s_tuser[0];
        end
        if (w_adv) begin
            for (int i = 0; i < AXES; i++) begin
                r_out_rate[i] <= w_rate[i];
            end
            r_out_cal  <= w_ctl.in_run;
            r_out_good <= n_passed;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {r_out_rate[2], r_out_rate[1], r_out_rate[0]};
    assign o_m_tuser  = {r_out_good, r_out_cal};

endmodule

@@ src/gbc_div.sv @@
// ----------------------------------------------------------------------------
// gbc_div: bias divider
// signed sum divided by CAL_POINTS, truncated toward zero, by reciprocal
// multiplication and a single correction step; four-stage pipeline
// ----------------------------------------------------------------------------
module gbc_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  gbc_pkg::t_sum   i_sum,
    output logic            o_busy,
    output logic            o_done,
    output gbc_pkg::t_sample o_quot
);
    import gbc_pkg::*;

    localparam logic [MAG_W-1:0] CAL_MAG = MAG_W'(CAL_POINTS);
    localparam logic [CNT_W:0]   CAL_REM = (CNT_W + 1)'(CAL_POINTS);

    logic                      r_v1, r_v2, r_v3, r_done;
    logic                      r_neg1, r_neg2, r_neg3;
    logic [MAG_W-1:0]          r_mag1, r_mag2;
    logic [MAG_W-1:0]          r_q2, r_q3;
    logic [CNT_W:0]            r_rem3;
    t_sample                   r_quot;

    logic [MAG_W-1:0]             n_mag;
    logic [MAG_W+RECIP_SHIFT-1:0] n_prod;
    logic [MAG_W-1:0]             n_qc;
    logic [MAG_W-1:0]             n_rem;
    logic [MAG_W-1:0]             n_q;
    t_sum                         n_abs;

    always_comb begin
        n_abs  = i_sum[SUM_W-1] ? -i_sum : i_sum;
        n_mag  = n_abs[MAG_W-1:0];
        n_prod = (MAG_W + RECIP_SHIFT)'(r_mag1) * (MAG_W + RECIP_SHIFT)'(RECIP);
        n_qc   = r_q2 * CAL_MAG;
        n_rem  = r_mag2 - n_qc;
        // estimate is low by at most one
        n_q    = (r_rem3 >= CAL_REM) ? r_q3 + MAG_W'(1) : r_q3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= i_start;
            r_v2   <= r_v1;
            r_v3   <= r_v2;
            r_done <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg1 <= i_sum[SUM_W-1];
        r_mag1 <= n_mag;
        r_neg2 <= r_neg1;
        r_mag2 <= r_mag1;
        r_q2   <= n_prod[RECIP_SHIFT +: MAG_W];
        r_neg3 <= r_neg2;
        r_q3   <= r_q2;
        r_rem3 <= n_rem[CNT_W:0];
        r_quot <= r_neg3 ? -SAMPLE_W'(n_q) : SAMPLE_W'(n_q);
    end

    assign o_busy = r_v1 | r_v2 | r_v3 | r_done;
    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

@@ src/gbc_lane.sv @@
// ----------------------------------------------------------------------------
// gbc_lane: one axis datapath
// run sum, deviation check, bias correction with saturation, glitch clamp
// ----------------------------------------------------------------------------
module gbc_lane (
    input  gbc_pkg::t_lane_ctl        i_ctl,
    input  gbc_pkg::t_sample          i_sample,
    input  gbc_pkg::t_sum             i_sum,
    input  gbc_pkg::t_sample          i_bias,
    input  gbc_pkg::t_sample          i_prev,
    input  logic [gbc_pkg::CFG_W-1:0] i_glitch_limit,
    input  logic [gbc_pkg::CFG_W-1:0] i_threshold,
    output gbc_pkg::t_sum             o_sum_next,
    output logic                      o_dev_bad,
    output gbc_pkg::t_sample          o_rate
);
    import gbc_pkg::*;

    localparam int DW = SAMPLE_W + 1;
    localparam int GW = SAMPLE_W + 2;
    localparam logic signed [DW-1:0] SAT_HI = DW'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [DW-1:0] SAT_LO = -DW'(1 << (SAMPLE_W - 1));

    logic signed [DW-1:0] n_diff;
    logic        [DW-1:0] n_mag;
    t_sample              n_corr;
    logic signed [GW-1:0] n_lo, n_hi, n_val, n_gl;

    always_comb begin
        o_sum_next = (i_ctl.clr_sum ? '0 : i_sum) + SUM_W'(i_sample);

        n_diff    = DW'(i_sample) - DW'(i_bias);
        n_mag     = n_diff[DW-1] ? DW'(-n_diff) : DW'(n_diff);
        o_dev_bad = n_mag > DW'(i_threshold);

        priority if (i_ctl.in_run) begin
            n_corr = '0;
        end else if (i_ctl.skip_bias) begin
            n_corr = i_sample;
        end else if (n_diff > SAT_HI) begin
            n_corr = SAT_HI[SAMPLE_W-1:0];
        end else if (n_diff < SAT_LO) begin
            n_corr = SAT_LO[SAMPLE_W-1:0];
        end else begin
            n_corr = n_diff[SAMPLE_W-1:0];
        end

        // limit the step from the previous output
        n_gl  = $signed({2'b00, i_glitch_limit});
        n_lo  = GW'(i_prev) - n_gl;
        n_hi  = GW'(i_prev) + n_gl;
        n_val = GW'(n_corr);
        if (n_val < n_lo) begin
            n_val = n_lo;
        end
        if (n_val > n_hi) begin
            n_val = n_hi;
        end
        o_rate = n_val[SAMPLE_W-1:0];
    end

endmodule

@@ src/gbc_checker.sv @@
// ----------------------------------------------------------------------------
// gbc_port_checks: port-level checks of the gyro bias calibration block
// watches the top-level ports only; attached by bind
// ----------------------------------------------------------------------------
module gbc_port_checks (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_tvalid,
    input logic                           o_s_tready,
    input logic [47:0]                    i_s_tdata,
    input logic [0:0]                     i_s_tuser,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [47:0]                    o_m_tdata,
    input logic [1:0]                     o_m_tuser
);

    // reset empties the result register
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result still valid after reset");

    // a calibrating item never reports a good bias
    a_cal_not_good: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tuser[0] && o_m_tuser[1]))
        else $error("calibrating and bias_good both set");

    // a stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result item changed");

    // a waiting sample item holds until it is taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && !o_s_tready |=>
            i_s_tvalid && $stable(i_s_tdata) && $stable(i_s_tuser))
        else $error("waiting sample item changed");

endmodule

bind gyro_bias_calibrate_and_deglitch_core gbc_port_checks u_gbc_port_checks (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_s_tvalid  (i_s_tvalid),
    .o_s_tready  (o_s_tready),
    .i_s_tdata   (i_s_tdata),
    .i_s_tuser   (i_s_tuser),
    .o_m_tvalid  (o_m_tvalid),
    .i_m_tready  (i_m_tready),
    .o_m_tdata   (o_m_tdata),
    .o_m_tuser   (o_m_tuser)
);
